// ===== sv/minmax_contrast_stretch_macros.svh =====
// ----------------------------------------------------------------------------
// Min-max contrast stretch assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MINMAX_CONTRAST_STRETCH_MACROS_SVH
`define MINMAX_CONTRAST_STRETCH_MACROS_SVH

// Check that cond implies prop in the same cycle
`define MMCS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("mmcs: same-cycle check failed");

// Check that cond implies prop in the following cycle
`define MMCS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("mmcs: next-cycle check failed");

`endif

// ===== sv/mmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-max contrast stretch package
// Shared widths, constants and divider interface types.
// ----------------------------------------------------------------------------
package mmcs_pkg;

   localparam int CHAN_COUNT = 3;
   localparam int SAMPLE_W   = 8;
   localparam int NUMER_W    = 2 * SAMPLE_W;
   localparam int DIV_STEPS  = SAMPLE_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int CHAN_W     = 2;

   localparam logic [SAMPLE_W-1:0] PIXEL_TOP = '1;
   localparam logic [SAMPLE_W-1:0] PIXEL_BOT = '0;

   // Pixel commands carried in tuser[0]
   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_MAP     = 1'b1;

   // Request into the shared divider
   typedef struct packed {
      logic                start;
      logic [NUMER_W-1:0]  numer;
      logic [SAMPLE_W-1:0] denom;
   } div_req_type;

   // Status and quotient out of the shared divider
   typedef struct packed {
      logic                busy;
      logic                done;
      logic [SAMPLE_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== sv/mmcs_div.sv =====
// ----------------------------------------------------------------------------
// Shared restoring divider
// Divides a 16-bit numerator by an 8-bit divisor, one quotient bit per cycle.
// The caller guarantees the quotient fits in 8 bits (numer < 256 * denom).
// ----------------------------------------------------------------------------
module mmcs_div
   import mmcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [SAMPLE_W-1:0] low_ff, low_in;
   logic [SAMPLE_W-1:0] quot_ff, quot_in;
   logic [SAMPLE_W-1:0] den_ff, den_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [SAMPLE_W:0]   trial;
   logic                fits;

   // One restoring step: shift in the next numerator bit, try the subtract
   always_comb begin
      trial = {rem_ff, low_ff[SAMPLE_W-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         // Load: the high byte is already below the divisor
         rem_in  = div_req.numer[NUMER_W-1:SAMPLE_W];
         low_in  = div_req.numer[SAMPLE_W-1:0];
         den_in  = div_req.denom;
         quot_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? SAMPLE_W'(trial - {1'b0, den_ff}) : trial[SAMPLE_W-1:0];
         low_in  = {low_ff[SAMPLE_W-2:0], 1'b0};
         quot_in = {quot_ff[SAMPLE_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control under reset, datapath free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== sv/minmax_contrast_stretch.sv =====
// ----------------------------------------------------------------------------
// Min-max contrast stretch
// Per-channel running min/max measure and linear stretch of up to 3 channels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel per transaction: tuser[0] selects measure (0) or
//   map (1), tuser[1] restarts min/max on a measure. tdata holds channels
//   0..2 from the low byte up. rsp_* returns one stretched pixel per map
//   transaction; measure transactions return nothing. csr_we/csr_wdata set
//   the number of active channels (idle only); unused channels map to zero.
// Sequencing:
//   A measure updates min/max on the accepting edge.
//   A map walks the channels one at a time through the shared divider:
//   a channel that needs no divide is resolved in S_CHAN, one that does
//   goes from S_CHAN to S_DIV and waits for the 8-step restoring divider,
//   then S_PUSH loads the output register. req_tready is only high in
//   S_IDLE, between items, so no new pixel is taken while a map runs.
// Reset:
//   Synchronous, active high: min goes to 255, max to 0, channel count to
//   3, output register empties.
// Stall:
//   A finished pixel waits in the output register; measures are still
//   taken meanwhile, and the next map holds before its output load until
//   rsp_tready drains the register.
// ----------------------------------------------------------------------------
`include "minmax_contrast_stretch_macros.svh"

module minmax_contrast_stretch
   import mmcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,    // active_channels
   // pixel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // chan0_value, chan1_value, chan2_value
   input  logic [1:0]  req_tuser,    // cmd, first_of_frame
   // stretched output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata     // stretched0, stretched1, stretched2
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CHAN = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [1:0]          active_ff;
   logic [SAMPLE_W-1:0] min_ff   [CHAN_COUNT];
   logic [SAMPLE_W-1:0] max_ff   [CHAN_COUNT];
   logic [SAMPLE_W-1:0] samp_ff  [CHAN_COUNT];
   logic [SAMPLE_W-1:0] res_ff   [CHAN_COUNT];
   logic [SAMPLE_W-1:0] res_val;
   logic                res_we;
   logic                rsp_valid_ff;
   logic [23:0]         rsp_data_ff;

   logic [CHAN_W-1:0]   used;
   logic                accept;
   logic                is_map;
   logic [SAMPLE_W-1:0] req_samp [CHAN_COUNT];
   logic [SAMPLE_W-1:0] k_val, lo_val, hi_val, diff;
   logic                out_free;
   logic                div_start;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // Effective channel count, limited to the channels present
   always_comb begin
      used = (active_ff > CHAN_W'(CHAN_COUNT)) ? CHAN_W'(CHAN_COUNT) : active_ff;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_map     = (req_tuser[0] == CMD_MAP);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   for (genvar g = 0; g < CHAN_COUNT; g++) begin : g_unpack
      assign req_samp[g] = req_tdata[g*SAMPLE_W +: SAMPLE_W];
   end

   // Current channel operands for the stretch
   always_comb begin
      k_val  = samp_ff[chan_ff];
      lo_val = min_ff[chan_ff];
      hi_val = max_ff[chan_ff];
      diff   = k_val - lo_val;
      div_req.start = div_start;
      div_req.numer = {diff, {SAMPLE_W{1'b0}}} - {{SAMPLE_W{1'b0}}, diff};
      div_req.denom = hi_val - lo_val;
   end

   // Sequencer: walk channels, start divides, load the output
   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      res_we    = 1'b0;
      res_val   = PIXEL_BOT;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && is_map) begin
               state_in = S_CHAN;
               chan_in  = '0;
            end
         end
         S_CHAN: begin
            if (chan_ff >= used || k_val <= lo_val) begin
               res_we  = 1'b1;
               res_val = PIXEL_BOT;
            end else if (k_val > hi_val) begin
               res_we  = 1'b1;
               res_val = PIXEL_TOP;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
            if (res_we) begin
               if (chan_ff == CHAN_W'(CHAN_COUNT - 1)) begin
                  state_in = S_PUSH;
               end else begin
                  chan_in = chan_ff + 1'b1;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_we  = 1'b1;
               res_val = div_rsp.quot;
               if (chan_ff == CHAN_W'(CHAN_COUNT - 1)) begin
                  state_in = S_PUSH;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = S_CHAN;
               end
            end
         end
         S_PUSH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control, configuration and min/max state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= '0;
         active_ff    <= 2'd3;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHAN_COUNT; c++) begin
            min_ff[c] <= PIXEL_TOP;
            max_ff[c] <= PIXEL_BOT;
         end
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         // Fold a measured pixel into the running range
         if (accept && (req_tuser[0] == CMD_MEASURE)) begin
            for (int c = 0; c < CHAN_COUNT; c++) begin
               if (CHAN_W'(c) < used) begin
                  if (req_tuser[1]) begin
                     min_ff[c] <= req_samp[c];
                     max_ff[c] <= req_samp[c];
                  end else begin
                     if (req_samp[c] < min_ff[c]) min_ff[c] <= req_samp[c];
                     if (req_samp[c] > max_ff[c]) max_ff[c] <= req_samp[c];
                  end
               end
            end
         end
         // Output register: drop on take, load on push
         if (state_ff == S_PUSH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Sample, per-channel result and output payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int c = 0; c < CHAN_COUNT; c++) begin
            samp_ff[c] <= req_samp[c];
         end
      end
      if (res_we) begin
         res_ff[chan_ff] <= res_val;
      end
      if (state_ff == S_PUSH && out_free) begin
         for (int c = 0; c < CHAN_COUNT; c++) begin
            rsp_data_ff[c*SAMPLE_W +: SAMPLE_W] <= res_ff[c];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   mmcs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Checks on sequencer and divider cooperation
   `MMCS_ASSERT_IMPLY(a_start_idle_div, clock, reset, div_req.start, !div_rsp.busy)
   `MMCS_ASSERT_IMPLY(a_done_in_div, clock, reset, div_rsp.done, state_ff == S_DIV)
   `MMCS_ASSERT_NEXT(a_map_starts_chan0, clock, reset, accept && is_map,
                     state_ff == S_CHAN && chan_ff == '0)
   `MMCS_ASSERT_NEXT(a_push_loads_out, clock, reset, state_ff == S_PUSH && out_free,
                     rsp_valid_ff && state_ff == S_IDLE)

endmodule
